FILE: rtl/sbkv_pkg.sv
// sbkv_pkg: shared constants, codes and types of the sorted block key-value store
// no dependencies; imported by every other file of the block
package sbkv_pkg;

   localparam int KEY_W   = 14;
   localparam int VAL_W   = 14;
   localparam int REC_W   = KEY_W + VAL_W;
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 2;
   localparam int RESTR_W = 2;
   localparam int BLKNO_W = 7;
   localparam int RPB_W   = 5;

   localparam logic [RPB_W-1:0] RPB_RESET = 5'd4;
   localparam int               RPB_MIN   = 2;
   localparam logic             REG_RPB   = 1'b0;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2
   } status_type;

   typedef enum logic [RESTR_W-1:0] {
      RESTR_NONE   = 2'd0,
      RESTR_SPLIT  = 2'd1,
      RESTR_BORROW = 2'd2,
      RESTR_MERGE  = 2'd3
   } restr_type;

   typedef logic [REC_W-1:0] rec_type;

   typedef struct packed {
      logic    clear;
      logic    ins;
      logic    pop;
      rec_type rec;
   } cell_cmd_type;

endpackage

FILE: rtl/sbkv_if.sv
// sbkv_req_if and sbkv_rsp_if: valid/ready channels for request and result items
// depends on sbkv_pkg for the field widths
interface sbkv_req_if;
   import sbkv_pkg::*;
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [KEY_W-1:0]   key;
   logic [VAL_W-1:0]   value;
   modport source (output valid, output mode, output key, output value, input ready);
   modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface sbkv_rsp_if;
   import sbkv_pkg::*;
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [VAL_W-1:0]   found_value;
   logic [BLKNO_W-1:0] block_number;
   logic [RESTR_W-1:0] restructure;
   modport source (output valid, output status, output found_value, output block_number,
                   output restructure, input ready);
   modport sink   (input valid, input status, input found_value, input block_number,
                   input restructure, output ready);
endinterface

FILE: rtl/sbkv_cells.sv
// sbkv_cells: row of record cells kept sorted, with parallel insert, pop and clear
// depends on sbkv_pkg
module sbkv_cells #(
   parameter int DEPTH = 17,
   parameter int CW    = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sbkv_pkg::cell_cmd_type cmd,
   output sbkv_pkg::rec_type      head,
   output logic [CW-1:0]          count
);
   import sbkv_pkg::*;

   rec_type          cell_ff [DEPTH];
   rec_type          cell_in [DEPTH];
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DEPTH-1:0] lt;

   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         lt[k] = (CW'(k) < cnt_ff) && (cell_ff[k] <= cmd.rec);
      end
      cell_in = cell_ff;
      cnt_in  = cnt_ff;
      if (cmd.clear) begin
         cnt_in = '0;
      end else if (cmd.ins) begin
         cell_in[0] = lt[0] ? cell_ff[0] : cmd.rec;
         for (int k = 1; k < DEPTH; k++) begin
            if (lt[k]) begin
               cell_in[k] = cell_ff[k];
            end else if (lt[k-1]) begin
               cell_in[k] = cmd.rec;
            end else begin
               cell_in[k] = cell_ff[k-1];
            end
         end
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.pop) begin
         for (int k = 0; k < DEPTH - 1; k++) begin
            cell_in[k] = cell_ff[k+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign head  = cell_ff[0];
   assign count = cnt_ff;

endmodule

FILE: rtl/sbkv_rec_mem.sv
// sbkv_rec_mem: record slot memory, one row per block, with a row-written flag per block
// depends on sbkv_pkg; rows never written read as empty
module sbkv_rec_mem #(
   parameter int NUM_BLOCKS = 64,
   parameter int BW         = 7,
   parameter int IW         = 6,
   parameter int SW         = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [BW-1:0]     rd_blk,
   input  logic [SW-1:0]     rd_slot,
   output logic [sbkv_pkg::REC_W:0] rd_data,
   input  logic              wr_en,
   input  logic [BW-1:0]     wr_blk,
   input  logic [SW-1:0]     wr_slot,
   input  logic [sbkv_pkg::REC_W:0] wr_data,
   input  logic              row_done,
   output logic              row_vld
);
   import sbkv_pkg::*;

   localparam int DEPTH = NUM_BLOCKS * (2 ** SW);

   logic [REC_W:0]        mem [DEPTH];
   logic [REC_W:0]        q_ff;
   logic                  qv_ff;
   logic [NUM_BLOCKS-1:0] row_vld_ff;
   logic [IW-1:0]         rd_idx, wr_idx;

   assign rd_idx  = IW'(rd_blk - 1'b1);
   assign wr_idx  = IW'(wr_blk - 1'b1);
   assign row_vld = row_vld_ff[wr_idx];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{wr_idx, wr_slot}] <= wr_data;
      end
      if (rd_en) begin
         q_ff  <= mem[{rd_idx, rd_slot}];
         qv_ff <= row_vld_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (row_done) begin
         row_vld_ff[wr_idx] <= 1'b1;
      end
   end

   assign rd_data = qv_ff ? q_ff : '0;

endmodule

FILE: rtl/sbkv_tbl_mem.sv
// sbkv_tbl_mem: per-block link and largest key memory with entry-written flags
// depends on sbkv_pkg; unwritten entries read as the chain i to i+1 and key zero
module sbkv_tbl_mem #(
   parameter int NUM_BLOCKS = 64,
   parameter int BW         = 7,
   parameter int IW         = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [BW-1:0]             rd_blk,
   output logic [BW-1:0]             rd_next,
   output logic [sbkv_pkg::KEY_W-1:0] rd_max,
   input  logic                      wr_en,
   input  logic [BW-1:0]             wr_blk,
   input  logic [BW-1:0]             wr_next,
   input  logic [sbkv_pkg::KEY_W-1:0] wr_max
);
   import sbkv_pkg::*;

   logic [BW+KEY_W-1:0]   mem [NUM_BLOCKS];
   logic [BW+KEY_W-1:0]   q_ff;
   logic                  qv_ff;
   logic [BW-1:0]         qblk_ff;
   logic [NUM_BLOCKS-1:0] vld_ff;
   logic [IW-1:0]         rd_idx, wr_idx;

   assign rd_idx = IW'(rd_blk - 1'b1);
   assign wr_idx = IW'(wr_blk - 1'b1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= {wr_next, wr_max};
      end
      if (rd_en) begin
         q_ff    <= mem[rd_idx];
         qv_ff   <= vld_ff[rd_idx];
         qblk_ff <= rd_blk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_idx] <= 1'b1;
      end
   end

   always_comb begin
      if (qv_ff) begin
         rd_next = q_ff[BW+KEY_W-1:KEY_W];
         rd_max  = q_ff[KEY_W-1:0];
      end else begin
         rd_next = (qblk_ff < BW'(NUM_BLOCKS)) ? qblk_ff + 1'b1 : '0;
         rd_max  = '0;
      end
   end

endmodule

FILE: rtl/sorted_block_key_value_store_core.sv
// sorted_block_key_value_store_core: top level, sequencer, csr port and result register
// depends on sbkv_pkg, sbkv_if, sbkv_cells, sbkv_rec_mem, sbkv_tbl_mem
//
// One request item is handled at a time. The sequencer walks the block chain through the
// link table memory, loads a block into a sorted cell row, and writes a block back. An
// insert loads and writes back one block, a split one more block write, a delete with
// borrow or merge up to two more loads and writes; search needs no write-back. A new
// item is taken while the previous result waits in the output register. No clearing pass
// is needed after reset; the user must write records_per_block only while the block is
// idle, and the block itself does not enforce it.
module sorted_block_key_value_store_core #(
   parameter int NUM_BLOCKS  = 64,
   parameter int MAX_RECORDS = 16
) (
   input  logic         clock,
   input  logic         reset,
   sbkv_req_if.sink     req_chan,
   sbkv_rsp_if.source   rsp_chan,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import sbkv_pkg::*;

   localparam int BW    = $clog2(NUM_BLOCKS + 1);
   localparam int IW    = $clog2(NUM_BLOCKS);
   localparam int SW    = $clog2(MAX_RECORDS);
   localparam int DEPTH = MAX_RECORDS + 1;
   localparam int NW    = $clog2(MAX_RECORDS + 2);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_WALK  = 10'b0000000010,
      ST_WCHK  = 10'b0000000100,
      ST_LOAD  = 10'b0000001000,
      ST_INS   = 10'b0000010000,
      ST_STORE = 10'b0000100000,
      ST_TRD   = 10'b0001000000,
      ST_NEXT  = 10'b0010000000,
      ST_DONE  = 10'b0100000000,
      ST_SPARE = 10'b1000000000
   } state_type;

   typedef enum logic [12:0] {
      P_MAIN = 13'b0000000000001,
      P_INSD = 13'b0000000000010,
      P_SPL1 = 13'b0000000000100,
      P_SPL2 = 13'b0000000001000,
      P_END  = 13'b0000000010000,
      P_DEL  = 13'b0000000100000,
      P_NBT  = 13'b0000001000000,
      P_NB   = 13'b0000010000000,
      P_BOR1 = 13'b0000100000000,
      P_BOR2 = 13'b0001000000000,
      P_BOR3 = 13'b0010000000000,
      P_MRG1 = 13'b0100000000000,
      P_MRG2 = 13'b1000000000000
   } phase_type;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   logic [NW-1:0]      n_ff, n_in, minn_ff, minn_in;
   logic               started_ff, started_in;
   logic [BW-1:0]      free_ff, free_in, cur_ff, cur_in;
   logic [BW-1:0]      blk_ff, blk_in, blk_next_ff, blk_next_in;
   logic [BW-1:0]      nb_ff, nb_in, nb_next_ff, nb_next_in, f_ff, f_in;
   logic [NW-1:0]      cnt_ff, cnt_in;
   rec_type            hold_ff, hold_in, best_ff, best_in;
   logic               match_ff, match_in;
   logic [BW-1:0]      ld_blk_ff, ld_blk_in;
   logic [NW-1:0]      ld_slot_ff, ld_slot_in;
   logic               ld_pend_ff, ld_pend_in;
   logic [BW-1:0]      st_blk_ff, st_blk_in, st_next_ff, st_next_in;
   logic [NW-1:0]      st_cnt_ff, st_cnt_in;
   logic [SW-1:0]      st_slot_ff, st_slot_in;
   logic               st_skip_ff, st_skip_in;
   logic [KEY_W-1:0]   st_max_ff, st_max_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic [VAL_W-1:0]   res_found_ff, res_found_in;
   logic [RESTR_W-1:0] res_restr_ff, res_restr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]   rsp_found_ff, rsp_found_in;
   logic [BLKNO_W-1:0] rsp_blk_ff, rsp_blk_in;
   logic [RESTR_W-1:0] rsp_restr_ff, rsp_restr_in;
   logic [RPB_W-1:0]   rpb_ff, rpb_in;

   cell_cmd_type       cmd;
   rec_type            cell_head;
   logic [NW-1:0]      cell_cnt;

   logic               tbl_rd_en, tbl_wr_en;
   logic [BW-1:0]      tbl_rd_blk, tbl_rd_next, tbl_wr_blk, tbl_wr_next;
   logic [KEY_W-1:0]   tbl_rd_max, tbl_wr_max;

   logic               rec_rd_en, rec_wr_en, rec_row_done, rec_row_vld;
   logic [BW-1:0]      rec_rd_blk, rec_wr_blk;
   logic [SW-1:0]      rec_rd_slot, rec_wr_slot;
   logic [REC_W:0]     rec_rd_data, rec_wr_data;

   logic               csr_wr;
   logic [6:0]         n_raw;
   logic [NW-1:0]      n_eff;
   rec_type            new_rec;

   sbkv_cells #(.DEPTH(DEPTH), .CW(NW)) u_cells (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .head  (cell_head),
      .count (cell_cnt)
   );

   sbkv_rec_mem #(.NUM_BLOCKS(NUM_BLOCKS), .BW(BW), .IW(IW), .SW(SW)) u_rec_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rec_rd_en),
      .rd_blk   (rec_rd_blk),
      .rd_slot  (rec_rd_slot),
      .rd_data  (rec_rd_data),
      .wr_en    (rec_wr_en),
      .wr_blk   (rec_wr_blk),
      .wr_slot  (rec_wr_slot),
      .wr_data  (rec_wr_data),
      .row_done (rec_row_done),
      .row_vld  (rec_row_vld)
   );

   sbkv_tbl_mem #(.NUM_BLOCKS(NUM_BLOCKS), .BW(BW), .IW(IW)) u_tbl_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (tbl_rd_en),
      .rd_blk  (tbl_rd_blk),
      .rd_next (tbl_rd_next),
      .rd_max  (tbl_rd_max),
      .wr_en   (tbl_wr_en),
      .wr_blk  (tbl_wr_blk),
      .wr_next (tbl_wr_next),
      .wr_max  (tbl_wr_max)
   );

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_psel && csr_paddr[2] == REG_RPB) ?
                       {{(32 - RPB_W){1'b0}}, rpb_ff} : 32'd0;

   always_comb begin
      rpb_in = rpb_ff;
      if (csr_wr && csr_paddr[2] == REG_RPB) begin
         rpb_in = csr_pwdata[RPB_W-1:0];
      end
   end

   // saturated slots per block
   always_comb begin
      n_raw = {2'b00, rpb_ff};
      if (n_raw < 7'(RPB_MIN)) begin
         n_raw = 7'(RPB_MIN);
      end else if (n_raw > 7'(MAX_RECORDS)) begin
         n_raw = 7'(MAX_RECORDS);
      end
      n_eff = NW'(n_raw);
   end

   assign new_rec        = {key_ff, val_ff};
   assign req_chan.ready = (state_ff == ST_IDLE);

   function automatic logic ok_block(input logic [BW-1:0] b);
      ok_block = (b != '0) && (b <= BW'(NUM_BLOCKS));
   endfunction

   always_comb begin
      logic [KEY_W-1:0] last_max;
      last_max      = st_max_ff;
      state_in      = state_ff;
      phase_in      = phase_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      n_in          = n_ff;
      minn_in       = minn_ff;
      started_in    = started_ff;
      free_in       = free_ff;
      cur_in        = cur_ff;
      blk_in        = blk_ff;
      blk_next_in   = blk_next_ff;
      nb_in         = nb_ff;
      nb_next_in    = nb_next_ff;
      f_in          = f_ff;
      cnt_in        = cnt_ff;
      hold_in       = hold_ff;
      best_in       = best_ff;
      match_in      = match_ff;
      ld_blk_in     = ld_blk_ff;
      ld_slot_in    = ld_slot_ff;
      ld_pend_in    = ld_pend_ff;
      st_blk_in     = st_blk_ff;
      st_next_in    = st_next_ff;
      st_cnt_in     = st_cnt_ff;
      st_slot_in    = st_slot_ff;
      st_skip_in    = st_skip_ff;
      st_max_in     = st_max_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_restr_in  = res_restr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_blk_in    = rsp_blk_ff;
      rsp_restr_in  = rsp_restr_ff;
      cmd           = '0;
      tbl_rd_en     = 1'b0;
      tbl_rd_blk    = cur_ff;
      tbl_wr_en     = 1'b0;
      tbl_wr_blk    = st_blk_ff;
      tbl_wr_next   = st_next_ff;
      tbl_wr_max    = st_max_ff;
      rec_rd_en     = 1'b0;
      rec_rd_blk    = ld_blk_ff;
      rec_rd_slot   = ld_slot_ff[SW-1:0];
      rec_wr_en     = 1'b0;
      rec_wr_blk    = st_blk_ff;
      rec_wr_slot   = st_slot_ff;
      rec_wr_data   = '0;
      rec_row_done  = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               mode_in       = req_chan.mode;
               key_in        = req_chan.key;
               val_in        = req_chan.value;
               n_in          = n_eff;
               minn_in       = NW'((n_eff + 1'b1) >> 1);
               res_status_in = STAT_OK;
               res_found_in  = '0;
               res_restr_in  = RESTR_NONE;
               blk_in        = '0;
               cur_in        = BW'(1);
               if (req_chan.mode == MODE_INSERT) begin
                  if (!started_ff) begin
                     started_in  = 1'b1;
                     free_in     = BW'(2);
                     blk_in      = BW'(1);
                     blk_next_in = '0;
                     cmd.clear   = 1'b1;
                     ld_blk_in   = BW'(1);
                     ld_slot_in  = '0;
                     ld_pend_in  = 1'b0;
                     match_in    = 1'b0;
                     phase_in    = P_MAIN;
                     state_in    = ST_LOAD;
                  end else begin
                     state_in = ST_WALK;
                  end
               end else if (req_chan.mode == MODE_DELETE || req_chan.mode == MODE_SEARCH) begin
                  if (!started_ff) begin
                     res_status_in = STAT_NOT_FOUND;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_WALK;
                  end
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_WALK: begin
            tbl_rd_en = 1'b1;
            state_in  = ST_WCHK;
         end
         ST_WCHK: begin
            if (key_ff <= tbl_rd_max || !ok_block(tbl_rd_next)) begin
               blk_in      = cur_ff;
               blk_next_in = tbl_rd_next;
               cmd.clear   = 1'b1;
               ld_blk_in   = cur_ff;
               ld_slot_in  = '0;
               ld_pend_in  = 1'b0;
               match_in    = 1'b0;
               phase_in    = P_MAIN;
               state_in    = ST_LOAD;
            end else begin
               cur_in   = tbl_rd_next;
               state_in = ST_WALK;
            end
         end
         ST_LOAD: begin
            if (ld_pend_ff && rec_rd_data[REC_W]) begin
               cmd.ins = 1'b1;
               cmd.rec = rec_rd_data[REC_W-1:0];
               if (rec_rd_data[REC_W-1:VAL_W] == key_ff &&
                   (!match_ff || rec_rd_data[REC_W-1:0] < best_ff)) begin
                  best_in  = rec_rd_data[REC_W-1:0];
                  match_in = 1'b1;
               end
            end
            if (ld_slot_ff < n_ff) begin
               rec_rd_en  = 1'b1;
               ld_slot_in = ld_slot_ff + 1'b1;
               ld_pend_in = 1'b1;
            end else begin
               ld_pend_in = 1'b0;
               if (!ld_pend_ff) begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_INS: begin
            cmd.ins  = 1'b1;
            cmd.rec  = hold_ff;
            state_in = ST_NEXT;
         end
         ST_STORE: begin
            if (st_skip_ff && cell_cnt != '0 && cell_head == best_ff) begin
               cmd.pop    = 1'b1;
               st_skip_in = 1'b0;
            end else begin
               if (st_cnt_ff != '0) begin
                  rec_wr_en   = 1'b1;
                  rec_wr_data = {1'b1, cell_head};
                  cmd.pop     = 1'b1;
                  st_cnt_in   = st_cnt_ff - 1'b1;
                  last_max    = cell_head[REC_W-1:VAL_W];
                  st_max_in   = last_max;
               end else if (NW'(st_slot_ff) < n_ff || !rec_row_vld) begin
                  rec_wr_en   = 1'b1;
                  rec_wr_data = '0;
               end
               if (st_slot_ff == SW'(MAX_RECORDS - 1)) begin
                  tbl_wr_en    = 1'b1;
                  tbl_wr_max   = last_max;
                  rec_row_done = 1'b1;
                  state_in     = ST_NEXT;
               end else begin
                  st_slot_in = st_slot_ff + 1'b1;
               end
            end
         end
         ST_TRD: begin
            tbl_rd_en = 1'b1;
            state_in  = ST_NEXT;
         end
         ST_NEXT: begin
            unique case (phase_ff)
               P_MAIN: begin
                  if (mode_ff == MODE_INSERT) begin
                     cnt_in   = cell_cnt;
                     hold_in  = new_rec;
                     phase_in = P_INSD;
                     state_in = ST_INS;
                  end else if (!match_ff) begin
                     res_status_in = STAT_NOT_FOUND;
                     state_in      = ST_DONE;
                  end else if (mode_ff == MODE_SEARCH) begin
                     res_found_in = best_ff[VAL_W-1:0];
                     state_in     = ST_DONE;
                  end else begin
                     cnt_in     = cell_cnt - 1'b1;
                     st_blk_in  = blk_ff;
                     st_cnt_in  = cell_cnt - 1'b1;
                     st_next_in = blk_next_ff;
                     st_skip_in = 1'b1;
                     st_slot_in = '0;
                     st_max_in  = '0;
                     phase_in   = P_DEL;
                     state_in   = ST_STORE;
                  end
               end
               P_INSD: begin
                  if (cnt_ff < n_ff) begin
                     st_blk_in  = blk_ff;
                     st_cnt_in  = cnt_ff + 1'b1;
                     st_next_in = blk_next_ff;
                     st_skip_in = 1'b0;
                     st_slot_in = '0;
                     st_max_in  = '0;
                     phase_in   = P_END;
                     state_in   = ST_STORE;
                  end else if (!ok_block(free_ff)) begin
                     res_status_in = STAT_FULL;
                     state_in      = ST_DONE;
                  end else begin
                     f_in     = free_ff;
                     cur_in   = free_ff;
                     phase_in = P_SPL1;
                     state_in = ST_TRD;
                  end
               end
               P_SPL1: begin
                  free_in      = tbl_rd_next;
                  res_restr_in = RESTR_SPLIT;
                  st_blk_in    = blk_ff;
                  st_cnt_in    = n_ff - 1'b1;
                  st_next_in   = f_ff;
                  st_skip_in   = 1'b0;
                  st_slot_in   = '0;
                  st_max_in    = '0;
                  phase_in     = P_SPL2;
                  state_in     = ST_STORE;
               end
               P_SPL2: begin
                  st_blk_in  = f_ff;
                  st_cnt_in  = NW'(2);
                  st_next_in = blk_next_ff;
                  st_skip_in = 1'b0;
                  st_slot_in = '0;
                  st_max_in  = '0;
                  phase_in   = P_END;
                  state_in   = ST_STORE;
               end
               P_END: begin
                  state_in = ST_DONE;
               end
               P_DEL: begin
                  if (cnt_ff < minn_ff && ok_block(blk_next_ff)) begin
                     nb_in    = blk_next_ff;
                     cur_in   = blk_next_ff;
                     phase_in = P_NBT;
                     state_in = ST_TRD;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               P_NBT: begin
                  nb_next_in = tbl_rd_next;
                  cmd.clear  = 1'b1;
                  ld_blk_in  = nb_ff;
                  ld_slot_in = '0;
                  ld_pend_in = 1'b0;
                  phase_in   = P_NB;
                  state_in   = ST_LOAD;
               end
               P_NB: begin
                  if (cell_cnt > minn_ff) begin
                     hold_in      = cell_head;
                     cmd.pop      = 1'b1;
                     res_restr_in = RESTR_BORROW;
                     st_blk_in    = nb_ff;
                     st_cnt_in    = cell_cnt - 1'b1;
                     st_next_in   = nb_next_ff;
                     st_skip_in   = 1'b0;
                     st_slot_in   = '0;
                     st_max_in    = '0;
                     phase_in     = P_BOR1;
                     state_in     = ST_STORE;
                  end else begin
                     res_restr_in = RESTR_MERGE;
                     ld_blk_in    = blk_ff;
                     ld_slot_in   = '0;
                     ld_pend_in   = 1'b0;
                     phase_in     = P_MRG1;
                     state_in     = ST_LOAD;
                  end
               end
               P_BOR1: begin
                  cmd.clear  = 1'b1;
                  ld_blk_in  = blk_ff;
                  ld_slot_in = '0;
                  ld_pend_in = 1'b0;
                  phase_in   = P_BOR2;
                  state_in   = ST_LOAD;
               end
               P_BOR2: begin
                  phase_in = P_BOR3;
                  state_in = ST_INS;
               end
               P_BOR3: begin
                  st_blk_in  = blk_ff;
                  st_cnt_in  = cell_cnt;
                  st_next_in = blk_next_ff;
                  st_skip_in = 1'b0;
                  st_slot_in = '0;
                  st_max_in  = '0;
                  phase_in   = P_END;
                  state_in   = ST_STORE;
               end
               P_MRG1: begin
                  st_blk_in  = blk_ff;
                  st_cnt_in  = cell_cnt;
                  st_next_in = nb_next_ff;
                  st_skip_in = 1'b0;
                  st_slot_in = '0;
                  st_max_in  = '0;
                  phase_in   = P_MRG2;
                  state_in   = ST_STORE;
               end
               P_MRG2: begin
                  free_in    = nb_ff;
                  st_blk_in  = nb_ff;
                  st_cnt_in  = '0;
                  st_next_in = free_ff;
                  st_skip_in = 1'b0;
                  st_slot_in = '0;
                  st_max_in  = '0;
                  phase_in   = P_END;
                  state_in   = ST_STORE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_blk_in    = BLKNO_W'(blk_ff);
               rsp_restr_in  = res_restr_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= P_MAIN;
         started_ff   <= 1'b0;
         free_ff      <= BW'(1);
         rsp_valid_ff <= 1'b0;
         rpb_ff       <= RPB_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         started_ff   <= started_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         rpb_ff       <= rpb_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      n_ff          <= n_in;
      minn_ff       <= minn_in;
      cur_ff        <= cur_in;
      blk_ff        <= blk_in;
      blk_next_ff   <= blk_next_in;
      nb_ff         <= nb_in;
      nb_next_ff    <= nb_next_in;
      f_ff          <= f_in;
      cnt_ff        <= cnt_in;
      hold_ff       <= hold_in;
      best_ff       <= best_in;
      match_ff      <= match_in;
      ld_blk_ff     <= ld_blk_in;
      ld_slot_ff    <= ld_slot_in;
      ld_pend_ff    <= ld_pend_in;
      st_blk_ff     <= st_blk_in;
      st_next_ff    <= st_next_in;
      st_cnt_ff     <= st_cnt_in;
      st_slot_ff    <= st_slot_in;
      st_skip_ff    <= st_skip_in;
      st_max_ff     <= st_max_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_restr_ff  <= res_restr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_blk_ff    <= rsp_blk_in;
      rsp_restr_ff  <= rsp_restr_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.found_value  = rsp_found_ff;
   assign rsp_chan.block_number = rsp_blk_ff;
   assign rsp_chan.restructure  = rsp_restr_ff;

`ifndef SYNTH
   a_cells_bound: assert property (@(posedge clock) disable iff (reset)
      cell_cnt <= NW'(DEPTH))
      else $error("cell row overfilled");

   a_store_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE) |-> (st_blk_ff != '0 && st_blk_ff <= BW'(NUM_BLOCKS)))
      else $error("block write outside the block range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result item raised outside the done state");
`endif

endmodule

FILE: bench/sorted_block_key_value_store_core_tb.sv
// testbench for sorted_block_key_value_store_core: directed table then random insert, delete
// and search items, checked against a predictor of the block chain; depends on sbkv_pkg, sbkv_if
`timescale 1ns / 1ps
module sorted_block_key_value_store_core_tb;
   import sbkv_pkg::*;

   localparam int NBLK     = 64;
   localparam int MAXREC   = 16;
   localparam int LIMIT    = 3000000;
   localparam int SETTLE   = 800;

   typedef struct packed {
      status_type         status;
      logic [VAL_W-1:0]   found;
      logic [BLKNO_W-1:0] blk;
      restr_type          restr;
   } outcome_type;

   typedef struct packed {
      mode_type         mode;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      logic             typed;
      outcome_type      want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sbkv_req_if req_if ();
   sbkv_rsp_if rsp_if ();

   sorted_block_key_value_store_core #(.NUM_BLOCKS(NBLK), .MAX_RECORDS(MAXREC)) uut (
      .clock(clock), .reset(reset), .req_chan(req_if.sink), .rsp_chan(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mirror of the block store
   logic [REC_W:0]      slot_mem [1:NBLK][0:MAXREC-1];
   logic [KEY_W-1:0]    top_key  [0:NBLK];
   int                  link     [0:NBLK];
   int                  free_blk;
   logic                chain_on;
   logic [RPB_W-1:0]    rpb;

   outcome_type pending_q [$];
   dir_row_type next_typed_q [$];
   int  errors = 0;
   int  cycles = 0;
   bit  hold_req = 1'b0;
   bit  stim_done = 1'b0;

   function automatic int eff_n();
      if (rpb < RPB_MIN) return RPB_MIN;
      if (rpb > MAXREC) return MAXREC;
      return rpb;
   endfunction

   function automatic void order_recs(ref rec_type r [MAXREC+2], input int cnt);
      rec_type t;
      int j;
      for (int i = 1; i < cnt; i++) begin
         t = r[i];
         j = i;
         while (j > 0 && r[j-1] > t) begin
            r[j] = r[j-1];
            j--;
         end
         r[j] = t;
      end
   endfunction

   function automatic int load_blk(int b, ref rec_type r [MAXREC+2]);
      int cnt;
      cnt = 0;
      for (int s = 0; s < eff_n(); s++)
         if (slot_mem[b][s][REC_W]) begin
            r[cnt] = slot_mem[b][s][REC_W-1:0];
            cnt++;
         end
      order_recs(r, cnt);
      return cnt;
   endfunction

   function automatic void save_blk(int b, ref rec_type r [MAXREC+2], input int cnt);
      order_recs(r, cnt);
      for (int s = 0; s < eff_n(); s++)
         slot_mem[b][s] = (s < cnt) ? {1'b1, r[s]} : '0;
      top_key[b] = cnt ? r[cnt-1][REC_W-1:VAL_W] : '0;
   endfunction

   function automatic int locate_blk(logic [KEY_W-1:0] k);
      int cur;
      cur = 1;
      for (int i = 0; i < NBLK; i++) begin
         if (k <= top_key[cur] || link[cur] < 1 || link[cur] > NBLK) return cur;
         cur = link[cur];
      end
      return cur;
   endfunction

   function automatic outcome_type apply_item(logic [1:0] m, logic [KEY_W-1:0] k,
                                              logic [VAL_W-1:0] v);
      outcome_type o;
      rec_type r [MAXREC+2];
      rec_type rn [MAXREC+2];
      rec_type hi [MAXREC+2];
      int n, minn, cnt, cn, i, f, nb, b;
      o = '{STAT_OK, '0, '0, RESTR_NONE};
      n = eff_n();
      minn = (n + 1) / 2;
      case (mode_type'(m))
         MODE_INSERT: begin
            if (!chain_on) begin
               chain_on = 1'b1;
               free_blk = 2;
               link[1] = 0;
               b = 1;
            end else
               b = locate_blk(k);
            o.blk = BLKNO_W'(b);
            cnt = load_blk(b, r);
            if (cnt < n) begin
               r[cnt] = {k, v};
               save_blk(b, r, cnt + 1);
            end else if (free_blk < 1 || free_blk > NBLK) begin
               o.status = STAT_FULL;
            end else begin
               f = free_blk;
               r[cnt] = {k, v};
               order_recs(r, cnt + 1);
               free_blk = link[f];
               link[f] = link[b];
               link[b] = f;
               hi[0] = r[n-1];
               hi[1] = r[n];
               save_blk(b, r, n - 1);
               save_blk(f, hi, 2);
               o.restr = RESTR_SPLIT;
            end
         end
         MODE_DELETE, MODE_SEARCH: begin
            if (!chain_on)
               o.status = STAT_NOT_FOUND;
            else begin
               b = locate_blk(k);
               o.blk = BLKNO_W'(b);
               cnt = load_blk(b, r);
               for (i = 0; i < cnt; i++)
                  if (r[i][REC_W-1:VAL_W] == k) break;
               if (i == cnt)
                  o.status = STAT_NOT_FOUND;
               else if (mode_type'(m) == MODE_SEARCH)
                  o.found = r[i][VAL_W-1:0];
               else begin
                  for (; i + 1 < cnt; i++) r[i] = r[i+1];
                  cnt--;
                  save_blk(b, r, cnt);
                  nb = link[b];
                  if (cnt < minn && nb >= 1 && nb <= NBLK) begin
                     cn = load_blk(nb, rn);
                     if (cn > minn) begin
                        r[cnt] = rn[0];
                        for (i = 0; i + 1 < cn; i++) hi[i] = rn[i+1];
                        save_blk(nb, hi, cn - 1);
                        save_blk(b, r, cnt + 1);
                        o.restr = RESTR_BORROW;
                     end else begin
                        for (i = 0; i < cn && cnt < MAXREC; i++) begin
                           r[cnt] = rn[i];
                           cnt++;
                        end
                        save_blk(b, r, cnt);
                        save_blk(nb, rn, 0);
                        link[b] = link[nb];
                        link[nb] = free_blk;
                        free_blk = nb;
                        o.restr = RESTR_MERGE;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic report(string what);
      errors++;
      $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   // acceptance of request items: predict, or take the typed value of a directed row
   always @(posedge clock) begin
      outcome_type o;
      if (!reset && req_if.valid && req_if.ready) begin
         o = apply_item(req_if.mode, req_if.key, req_if.value);
         if (next_typed_q.size() > 0) begin
            if (next_typed_q[0].typed) o = next_typed_q[0].want;
            void'(next_typed_q.pop_front());
         end
         pending_q.insert(pending_q.size(), o);
      end
   end

   // result checker
   always @(posedge clock) begin
      outcome_type w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_q.size() == 0)
            report("result item with nothing expected");
         else begin
            w = pending_q.pop_front();
            if (rsp_if.status !== w.status)
               report($sformatf("status %0d, want %0d", rsp_if.status, w.status));
            if (rsp_if.found_value !== w.found)
               report($sformatf("found_value %0d, want %0d", rsp_if.found_value, w.found));
            if (rsp_if.block_number !== w.blk)
               report($sformatf("block_number %0d, want %0d", rsp_if.block_number, w.blk));
            if (rsp_if.restructure !== w.restr)
               report($sformatf("restructure %0d, want %0d", rsp_if.restructure, w.restr));
         end
      end
   end

   // receiver: own stall pattern, plus one long hold-off on request
   initial begin
      int hold;
      rsp_if.ready = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold_req && hold == 0) hold = 500;
         if (hold > 0) begin
            hold--;
            if (hold == 0) hold_req = 1'b0;
            rsp_if.ready <= 1'b0;
         end else if ((cycles % 300) < 120)
            rsp_if.ready <= 1'b1;
         else
            rsp_if.ready <= ($urandom_range(0, 2) != 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [31:0] d);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= 3'(REG_RPB) << 2;
      csr_pwdata <= d;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      rpb = d[RPB_W-1:0];
   endtask

   task automatic send(logic [1:0] m, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      req_if.valid <= 1'b1;
      req_if.mode  <= m;
      req_if.key   <= k;
      req_if.value <= v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_phase(int count, int key_top, int ins_pct, bit squeeze);
      int sent, burst, pick;
      bit squeezed;
      logic [1:0] m;
      logic [KEY_W-1:0] k;
      sent = 0;
      squeezed = 1'b0;
      while (sent < count) begin
         burst = $urandom_range(1, 10);
         if (squeeze && !squeezed && sent >= count / 3) begin
            hold_req = 1'b1;
            squeezed = 1'b1;
         end
         for (int i = 0; i < burst && sent < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < ins_pct) m = MODE_INSERT;
            else if (pick < 80) m = MODE_DELETE;
            else if (pick < 95) m = MODE_SEARCH;
            else m = MODE_NONE;
            if ($urandom_range(0, 9) == 0) k = KEY_W'($urandom_range(0, 16383));
            else k = KEY_W'($urandom_range(0, key_top));
            send(m, k, VAL_W'($urandom_range(0, 16383)));
            if (m != MODE_NONE) sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   dir_row_type dir_tab [18] = '{
      '{MODE_SEARCH, 14'd0,     14'd0,     1'b1, '{STAT_NOT_FOUND, 14'd0, 7'd0, RESTR_NONE}},
      '{MODE_DELETE, 14'd9999,  14'd0,     1'b1, '{STAT_NOT_FOUND, 14'd0, 7'd0, RESTR_NONE}},
      '{MODE_NONE,   14'd16383, 14'd16383, 1'b1, '{STAT_OK, 14'd0, 7'd0, RESTR_NONE}},
      '{MODE_INSERT, 14'd0,     14'd0,     1'b1, '{STAT_OK, 14'd0, 7'd1, RESTR_NONE}},
      '{MODE_INSERT, 14'd16383, 14'd16383, 1'b1, '{STAT_OK, 14'd0, 7'd1, RESTR_NONE}},
      '{MODE_INSERT, 14'd5,     14'd7,     1'b0, '0},
      '{MODE_INSERT, 14'd5,     14'd3,     1'b0, '0},
      '{MODE_INSERT, 14'd9999,  14'd9999,  1'b0, '0},
      '{MODE_SEARCH, 14'd5,     14'd0,     1'b0, '0},
      '{MODE_SEARCH, 14'd16383, 14'd0,     1'b0, '0},
      '{MODE_SEARCH, 14'd1234,  14'd0,     1'b0, '0},
      '{MODE_DELETE, 14'd1234,  14'd0,     1'b0, '0},
      '{MODE_INSERT, 14'd6,     14'd10922, 1'b0, '0},
      '{MODE_INSERT, 14'd7,     14'd5461,  1'b0, '0},
      '{MODE_DELETE, 14'd5,     14'd0,     1'b0, '0},
      '{MODE_DELETE, 14'd0,     14'd0,     1'b0, '0},
      '{MODE_DELETE, 14'd9999,  14'd0,     1'b0, '0},
      '{MODE_DELETE, 14'd5,     14'd0,     1'b0, '0}
   };

   initial begin
      req_if.valid = 1'b0;
      req_if.mode  = MODE_NONE;
      req_if.key   = '0;
      req_if.value = '0;
      for (int b = 1; b <= NBLK; b++)
         for (int s = 0; s < MAXREC; s++) slot_mem[b][s] = '0;
      for (int b = 0; b <= NBLK; b++) begin
         link[b] = (b >= 1 && b < NBLK) ? b + 1 : 0;
         top_key[b] = '0;
      end
      free_blk = 1;
      chain_on = 1'b0;
      rpb = RPB_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_tab[i]) begin
         next_typed_q.insert(next_typed_q.size(), dir_tab[i]);
         send(dir_tab[i].mode, dir_tab[i].key, dir_tab[i].value);
      end
      random_phase(90, 60, 55, 1'b1);
      drain();
      csr_write(32'd16);
      random_phase(100, 400, 55, 1'b0);
      drain();
      csr_write(32'd2);
      random_phase(120, 200, 60, 1'b0);
      drain();
      csr_write(32'd0);
      random_phase(80, 200, 30, 1'b0);
      drain();
      csr_write(32'd31);
      random_phase(90, 100, 40, 1'b0);
      drain();
      csr_write(32'd3);
      random_phase(80, 50, 35, 1'b0);
      drain();
      csr_write(32'd7);
      random_phase(80, 300, 50, 1'b0);
      drain();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
